/* rtl/hex_alarm_clock_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the hex alarm clock controller
// Concurrent assertion shorthands clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef HEX_ALARM_CLOCK_CONTROLLER_ASSERT_SVH
`define HEX_ALARM_CLOCK_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HACC_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hacc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HACC_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hacc assertion failed");

`endif

/* rtl/hacc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_pkg
// Shared types and constants of the hex alarm clock controller.
// ----------------------------------------------------------------------------
package hacc_pkg;

  localparam int TIME_W      = 16;
  localparam int NIB_W       = 4;
  localparam int NIB_CNT     = TIME_W / NIB_W;
  localparam int CUR_W       = $clog2(NIB_CNT);
  localparam int POINT_W     = NIB_CNT;
  localparam int KEY_CNT     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TIME_W-1:0]  SNOOZE_RESET = 16'h016C;
  localparam logic [NIB_W-1:0]   NIBBLE_MASK  = 4'hF;
  localparam logic [CUR_W-1:0]   TOP_CURSOR   = 2'd3;
  localparam logic [POINT_W-1:0] POINTS_UNSET = 4'hF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SNOOZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_SNOOZE    = 2'd1;

  // Key event taken from one sample: at most one press per sample.
  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_SET,
    KEY_INC,
    KEY_DOZE
  } key_t;

  // Classified request passed from the front end to the execution stage.
  typedef struct packed {
    logic is_sample;
    key_t key;
    logic sw;
    logic jumper;
  } hacc_item_t;

endpackage

/* rtl/hacc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_in_if
// Input request channel: tick or key and switch sample.
// ----------------------------------------------------------------------------
interface hacc_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic set_key;
  logic plus_key;
  logic snooze_key;
  logic alarm_switch;
  logic snooze_jumper;

  modport source (
    output valid, kind, set_key, plus_key, snooze_key, alarm_switch, snooze_jumper,
    input  ready
  );
  modport sink (
    input  valid, kind, set_key, plus_key, snooze_key, alarm_switch, snooze_jumper,
    output ready
  );
endinterface

/* rtl/hacc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_out_if
// Result channel: display value, points and status flags.
// ----------------------------------------------------------------------------
interface hacc_out_if;
  import hacc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  shown_value;
  logic [POINT_W-1:0] point_flags;
  logic               alarm_alert;
  logic               clock_set;
  logic               editing;

  modport source (
    output valid, shown_value, point_flags, alarm_alert, clock_set, editing,
    input  ready
  );
  modport sink (
    input  valid, shown_value, point_flags, alarm_alert, clock_set, editing,
    output ready
  );
endinterface

/* rtl/hacc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_front
// Accepts requests, edge-detects the keys and classifies each request.
// ----------------------------------------------------------------------------
module hacc_front
  import hacc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hacc_in_if.sink    in_chan,
  input  logic       q_full,
  output logic       push_valid,
  output hacc_item_t push_item
);

  logic [KEY_CNT-1:0] key_prev_r;
  logic [KEY_CNT-1:0] key_prev_nxt;
  logic [KEY_CNT-1:0] levels;
  logic [KEY_CNT-1:0] diff;
  logic               accept;
  key_t               key_evt;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign levels        = {in_chan.snooze_key, in_chan.plus_key, in_chan.set_key};
  assign diff          = levels ^ key_prev_r;

  // Only the first changed key (set, plus, snooze) is consumed per sample.
  always_comb begin
    key_prev_nxt = key_prev_r;
    key_evt      = KEY_NONE;
    if (diff[0]) begin
      key_prev_nxt[0] = levels[0];
      key_evt         = levels[0] ? KEY_SET : KEY_NONE;
    end else if (diff[1]) begin
      key_prev_nxt[1] = levels[1];
      key_evt         = levels[1] ? KEY_INC : KEY_NONE;
    end else if (diff[2]) begin
      key_prev_nxt[2] = levels[2];
      key_evt         = levels[2] ? KEY_DOZE : KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_prev_r <= '0;
    end else if (accept && in_chan.kind) begin
      key_prev_r <= key_prev_nxt;
    end
  end

  assign push_valid          = accept;
  assign push_item.is_sample = in_chan.kind;
  assign push_item.key       = in_chan.kind ? key_evt : KEY_NONE;
  assign push_item.sw        = in_chan.alarm_switch;
  assign push_item.jumper    = in_chan.snooze_jumper;

endmodule

/* rtl/hacc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_queue
// Short request queue between the front end and the execution stage.
// ----------------------------------------------------------------------------
`include "hex_alarm_clock_controller_assert.svh"
module hacc_queue
  import hacc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  hacc_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output hacc_item_t head_item
);

  hacc_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `HACC_AST_IMP(a_count_bound, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH))
  `HACC_AST_NXT(a_pop_drains, do_pop && !do_push && count_r == QCNT_W'(1), !head_valid)

endmodule

/* rtl/hacc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hacc_back
// Executes classified requests on the clock state and registers each result.
// ----------------------------------------------------------------------------
`include "hex_alarm_clock_controller_assert.svh"
module hacc_back
  import hacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  hacc_item_t           head_item,
  output logic                 pop,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  hacc_out_if.source           out_chan
);

  logic [TIME_W-1:0] dflt_snooze_r, user_snooze_r;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] setting_r, setting_nxt;
  logic [TIME_W-1:0] target_r, target_nxt;
  logic [TIME_W-1:0] edit_val_r, edit_val_nxt;
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic              snoozing_r, snoozing_nxt;
  logic              alerting_r, alerting_nxt;
  logic              is_set_r, is_set_nxt;
  logic              edit_r, edit_nxt;
  logic              edit_alarm_r, edit_alarm_nxt;
  logic              entry_sw_r, entry_sw_nxt;
  logic [NIB_W-1:0]  nib;
  logic [TIME_W-1:0] interval;

  logic               out_valid_r;
  logic [TIME_W-1:0]  shown_r, shown_nxt;
  logic [POINT_W-1:0] points_r, points_nxt;
  logic               alert_r, alert_nxt;

  assign pop      = head_valid && (!out_valid_r || out_chan.ready);
  assign interval = head_item.jumper ? user_snooze_r : dflt_snooze_r;
  assign nib      = edit_val_r[{cursor_r, 2'b00} +: NIB_W] + 1'b1;

  always_comb begin
    time_nxt       = time_r;
    setting_nxt    = setting_r;
    target_nxt     = target_r;
    edit_val_nxt   = edit_val_r;
    cursor_nxt     = cursor_r;
    snoozing_nxt   = snoozing_r;
    alerting_nxt   = alerting_r;
    is_set_nxt     = is_set_r;
    edit_nxt       = edit_r;
    edit_alarm_nxt = edit_alarm_r;
    entry_sw_nxt   = entry_sw_r;

    if (!head_item.is_sample) begin
      if (is_set_r) begin
        time_nxt = time_r + 1'b1;
      end
    end else if (edit_r) begin
      case (head_item.key)
        KEY_SET: begin
          if (cursor_r == '0) begin
            if (edit_alarm_r) begin
              setting_nxt = edit_val_r;
            end else begin
              time_nxt   = edit_val_r;
              is_set_nxt = 1'b1;
            end
            edit_nxt = 1'b0;
          end else begin
            cursor_nxt = cursor_r - 1'b1;
          end
        end
        KEY_INC: begin
          edit_val_nxt[{cursor_r, 2'b00} +: NIB_W] = nib & NIBBLE_MASK;
        end
        default: begin
        end
      endcase
      // A switch change throws the edit away.
      if (edit_nxt && head_item.sw != entry_sw_r) begin
        edit_nxt = 1'b0;
      end
    end else begin
      if (!snoozing_r) begin
        target_nxt = setting_r;
      end
      case (head_item.key)
        KEY_SET: begin
          edit_nxt       = 1'b1;
          edit_alarm_nxt = head_item.sw;
          entry_sw_nxt   = head_item.sw;
          edit_val_nxt   = head_item.sw ? setting_r : time_r;
          cursor_nxt     = TOP_CURSOR;
        end
        KEY_DOZE: begin
          if (alerting_r) begin
            snoozing_nxt = 1'b1;
            alerting_nxt = 1'b0;
            target_nxt   = time_r + interval;
          end
        end
        default: begin
        end
      endcase
    end

    // Alarm check whenever no edit is open after the request.
    if (!edit_nxt) begin
      if (!snoozing_nxt) begin
        target_nxt = setting_nxt;
      end
      if (head_item.sw && is_set_nxt && time_nxt == target_nxt) begin
        alerting_nxt = 1'b1;
      end else if (!head_item.sw) begin
        alerting_nxt = 1'b0;
        snoozing_nxt = 1'b0;
      end
    end

    shown_nxt  = edit_nxt ? edit_val_nxt : time_nxt;
    points_nxt = edit_nxt ? (POINT_W'(1) << cursor_nxt)
                          : (is_set_nxt ? '0 : POINTS_UNSET);
    alert_nxt  = alerting_nxt && !edit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_snooze_r <= SNOOZE_RESET;
      user_snooze_r <= SNOOZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEFAULT_SNOOZE: dflt_snooze_r <= cfg_wdata;
        CFG_USER_SNOOZE:    user_snooze_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      setting_r    <= '0;
      target_r     <= '0;
      edit_val_r   <= '0;
      cursor_r     <= TOP_CURSOR;
      snoozing_r   <= 1'b0;
      alerting_r   <= 1'b0;
      is_set_r     <= 1'b0;
      edit_r       <= 1'b0;
      edit_alarm_r <= 1'b0;
      entry_sw_r   <= 1'b0;
    end else if (pop) begin
      time_r       <= time_nxt;
      setting_r    <= setting_nxt;
      target_r     <= target_nxt;
      edit_val_r   <= edit_val_nxt;
      cursor_r     <= cursor_nxt;
      snoozing_r   <= snoozing_nxt;
      alerting_r   <= alerting_nxt;
      is_set_r     <= is_set_nxt;
      edit_r       <= edit_nxt;
      edit_alarm_r <= edit_alarm_nxt;
      entry_sw_r   <= entry_sw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shown_r  <= shown_nxt;
      points_r <= points_nxt;
      alert_r  <= alert_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.shown_value = shown_r;
  assign out_chan.point_flags = points_r;
  assign out_chan.alarm_alert = alert_r;
  assign out_chan.clock_set   = is_set_r;
  assign out_chan.editing     = edit_r;

  `HACC_AST_IMP(a_no_alert_in_edit, out_valid_r && edit_r, !alert_r)
  `HACC_AST_IMP(a_cursor_onehot, out_valid_r && edit_r, $onehot(points_r))
  `HACC_AST_NXT(a_set_sticky, is_set_r, is_set_r)

endmodule

/* rtl/hex_alarm_clock_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_alarm_clock_controller
// Alarm clock with nibble editor and snooze, driven by tick and key requests.
// ----------------------------------------------------------------------------
// An accepted request is written into the queue, then executed from its head into the result register.
// Throughput: one request per cycle, retired one per cycle while results are taken.
// A two-entry queue lets the input side keep going while a result waits.
// Reset (rst_n, synchronous, active low) clears time, alarm, edit and key
// history, sets the cursor to the top nibble and both snooze intervals to 0x16C.
// ----------------------------------------------------------------------------
module hex_alarm_clock_controller
  import hacc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  hacc_in_if.sink               in_chan,
  hacc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The front end keeps the key history and turns each sample into at most
  // one key press, so the execution stage only sees decoded events.
  logic       push_valid;
  hacc_item_t push_item;
  logic       q_full;

  // Queue head as seen by the execution stage.
  logic       head_valid;
  hacc_item_t head_item;
  logic       pop;

  hacc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // The queue decouples acceptance from execution; a stalled result register
  // backs up into it before the input side sees ready drop.
  hacc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The execution stage holds the whole clock state and the snooze registers,
  // runs one request per cycle while its results are taken, and registers each result.
  hacc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_chan   (out_chan)
  );

endmodule
